FILE: rtl/core/ppu_pkg.sv
`timescale 1ns / 1ps

package ppu_pkg;

   localparam int unsigned NumPoints  = 12;
   localparam int unsigned NibW       = 4;
   localparam int unsigned NumNibbles = 16;
   localparam int unsigned WordW      = 64;

   localparam logic [1:0] OP_COMPOSE = 2'd0;
   localparam logic [1:0] OP_INVERSE = 2'd1;
   localparam logic [1:0] OP_CHECK   = 2'd2;

   localparam logic [NumNibbles-1:0] FULL_SET = 16'h0FFF;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [WordW-1:0] perm_a;
      logic [WordW-1:0] perm_b;
   } req_type;

   typedef struct packed {
      logic [WordW-1:0] result_perm;
      logic             is_valid;
      logic             parity_odd;
   } rsp_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      logic [NibW-1:0]       comp_nib;
      logic [NumNibbles-1:0] hit;
      logic                  inv_par;
   } lane_out_type;

   typedef lane_out_type [NumPoints-1:0] lane_vec_type;

   function automatic logic [NibW-1:0] nib(input logic [WordW-1:0] w,
                                           input logic [NibW-1:0] idx);
      nib = w[idx*NibW +: NibW];
   endfunction

endpackage

FILE: rtl/core/ppu_lane.sv
`timescale 1ns / 1ps

module ppu_lane (
   input  logic [3:0]               lane_index,
   input  logic [63:0]              perm_a,
   input  logic [63:0]              perm_b,
   output ppu_pkg::lane_out_type    lane_out
);
   import ppu_pkg::*;

   logic [NibW-1:0] own;
   logic [NibW-1:0] sel;
   logic            par;

   // The lane's inversion parity counts pairs with this lane on the left.
   always_comb begin
      own = nib(perm_a, lane_index);
      sel = nib(perm_b, lane_index);
      par = 1'b0;
      for (int j = 0; j < NumPoints; j++) begin
         if (4'(j) > lane_index && own > nib(perm_a, 4'(j))) begin
            par = ~par;
         end
      end
      lane_out.comp_nib = nib(perm_a, sel);
      lane_out.hit      = NumNibbles'(1) << own;
      lane_out.inv_par  = par;
   end

endmodule

FILE: rtl/core/ppu_merge.sv
`timescale 1ns / 1ps

module ppu_merge (
   input  logic [1:0]            opcode,
   input  logic                  upper_zero,
   input  ppu_pkg::lane_vec_type lanes,
   output ppu_pkg::rsp_type      merged
);
   import ppu_pkg::*;

   logic [WordW-1:0]      comp_word;
   logic [WordW-1:0]      inv_word;
   logic [NumNibbles-1:0] seen;
   logic                  par;
   logic                  ok;

   always_comb begin
      comp_word = '0;
      inv_word  = '0;
      seen      = '0;
      par       = 1'b0;
      for (int i = 0; i < NumPoints; i++) begin
         comp_word[i*NibW +: NibW] = lanes[i].comp_nib;
         seen = seen | lanes[i].hit;
         par  = par ^ lanes[i].inv_par;
         for (int k = 0; k < NumNibbles; k++) begin
            if (lanes[i].hit[k]) begin
               inv_word[k*NibW +: NibW] = inv_word[k*NibW +: NibW] | 4'(i);
            end
         end
      end
      ok = upper_zero && (seen == FULL_SET);
      case (opcode)
         OP_COMPOSE: merged.result_perm = comp_word;
         OP_INVERSE: merged.result_perm = inv_word;
         default:    merged.result_perm = '0;
      endcase
      merged.is_valid   = ok;
      merged.parity_odd = ok & par;
   end

endmodule

FILE: rtl/core/packed_permutation_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | opcode, perm_a, perm_b
// rsp     | out       | rsp_valid / rsp_ready | result_perm, is_valid, parity_odd
//
// The twelve lanes work on the request payload and register at the accepting
// edge. The merge stage works on that stage-one register and loads the result
// register when stage two can advance, so a beat passes the stage-one and
// result registers before its result handshake.
// One beat is accepted per cycle while the result side keeps taking beats.
// A stalled result holds both stages; a bubble in either stage is filled.
// Reset clears only the two stage valid flags.

module packed_permutation_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppu_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppu_pkg::rsp_type  rsp_payload
);
   import ppu_pkg::*;

   // Stage one: one lane per point. Each lane fetches its compose nibble,
   // decodes where its image lands for the inverse, and counts the
   // inversions it starts, whose total parity is the permutation parity.
   lane_vec_type lane_res;

   for (genvar g = 0; g < NumPoints; g++) begin : g_lane
      ppu_lane u_lane (
         .lane_index (4'(g)),
         .perm_a     (req_payload.perm_a),
         .perm_b     (req_payload.perm_b),
         .lane_out   (lane_res[g])
      );
   end

   logic         s1_valid_ff, s1_valid_in;
   lane_vec_type s1_lanes_ff;
   logic [1:0]   s1_op_ff;
   logic         s1_uz_ff;
   logic         s1_adv;

   logic         s2_valid_ff, s2_valid_in;
   rsp_type      s2_rsp_ff;
   rsp_type      merged;
   logic         s2_adv;

   // Each stage loads when it is empty or its contents move on this cycle.
   assign s2_adv    = !s2_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   assign s1_valid_in = s1_adv ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_lanes_ff <= lane_res;
         s1_op_ff    <= req_payload.opcode;
         s1_uz_ff    <= (req_payload.perm_a[63:48] == 16'h0000);
      end
      if (s2_adv) begin
         s2_rsp_ff <= merged;
      end
   end

   // Stage two: the merge gathers the lanes into the result word, the
   // coverage set and the overall parity.
   ppu_merge u_merge (
      .opcode     (s1_op_ff),
      .upper_zero (s1_uz_ff),
      .lanes      (s1_lanes_ff),
      .merged     (merged)
   );

   assign rsp_valid   = s2_valid_ff;
   assign rsp_payload = s2_rsp_ff;

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted beat did not reach stage one");

   a_s1_held : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_adv |=> s1_valid_ff && $stable(s1_op_ff))
      else $error("stage one lost a stalled beat");

   a_parity_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_valid |-> !rsp_payload.parity_odd)
      else $error("odd parity on an invalid word");

   a_s2_from_s1 : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff && rsp_ready |=> !rsp_valid)
      else $error("result appeared without a beat in stage one");

endmodule
